// File: src/assert_macros.svh
// assertion macros shared by the list rtl
// no dependencies; included by the modules that check themselves
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define PIL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every rising clk edge outside reset
`define PIL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pil_pkg.sv
// shared constants, types and codes of the positional insert/remove list
// no dependencies
package pil_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int VAL_W    = 32;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_INS_REFUSED = 2'd1,
    ST_REM_REFUSED = 2'd2
  } status_t;

  // decoded request, valid only in the cycle an item is accepted
  typedef struct packed {
    logic ins_ok;
    logic rem_ok;
  } op_t;

  // per-cell update command
  typedef struct packed {
    logic load;
    logic shift_up;
    logic shift_dn;
  } cell_ctl_t;

endpackage

// File: src/positional_insert_remove_list.sv
// top level of the positional insert/remove list: a row of entry cells
// plus control; depends on pil_pkg, pil_cell and pil_ctrl
//
// Ordered list of up to CAPACITY signed 32-bit entries held in a row of
// cells. An item (start high while busy low) either inserts in_value at
// in_position, moving the entries at and above it up one cell, or removes
// the entry at in_position, moving the entries above it down one cell.
// All cells move together in the accept cycle, so the block takes one item
// per clock and busy is always low. The result of an item appears on the
// out_ ports in the cycle right after acceptance, marked by out_valid for
// exactly one cycle; the receiver cannot stall, so it must take every
// result as it comes. out_status reports ok, insert refused (list full or
// position above count) or remove refused (position at or above count),
// and a refused item leaves the list untouched. out_removed_value is the
// entry taken out by a good remove and zero otherwise; out_entry_count is
// the number of entries held after the item. Entries hold no reset value;
// only the count, the status and out_valid are cleared by rst_n.
module positional_insert_remove_list
  import pil_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_kind,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] out_removed_value,
  output logic [1:0]              out_status,
  output logic [4:0]              out_entry_count
);

  logic                    accept;
  op_t                     op;
  status_t                 status;
  logic [CNT_W-1:0]        count;
  logic [CMP_W-1:0]        pos_c;
  logic [IDX_W-1:0]        rd_idx;
  logic signed [VAL_W-1:0] entry_q [CAPACITY];
  cell_ctl_t               ctl     [CAPACITY];

  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic signed [VAL_W-1:0] removed_r;
  logic signed [VAL_W-1:0] removed_nxt;

  // every item finishes in its accept cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pos_c  = CMP_W'(in_position);
  assign rd_idx = IDX_W'(in_position);

  pil_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .kind     (in_kind),
    .position (in_position),
    .op       (op),
    .status   (status),
    .count    (count)
  );

  // the cell row: each cell looks only at its own index against position
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_value;
    logic signed [VAL_W-1:0] right_value;

    // cell 0 never shifts up; the top cell keeps its own value on shift down
    if (i == 0) begin : g_head
      assign left_value = in_value;
    end else begin : g_body
      assign left_value = entry_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = entry_q[i];
    end else begin : g_mid
      assign right_value = entry_q[i+1];
    end

    assign ctl[i].load     = accept && op.ins_ok && (CMP_W'(i) == pos_c);
    assign ctl[i].shift_up = accept && op.ins_ok && (CMP_W'(i) > pos_c);
    assign ctl[i].shift_dn = accept && op.rem_ok && (CMP_W'(i) >= pos_c);

    pil_cell u_cell (
      .clk         (clk),
      .ctl         (ctl[i]),
      .ins_value   (in_value),
      .left_value  (left_value),
      .right_value (right_value),
      .entry       (entry_q[i])
    );
  end

  // removed entry is picked before the row moves; zero for anything else
  always_comb begin
    removed_nxt   = removed_r;
    out_valid_nxt = accept;
    if (accept) begin
      removed_nxt = op.rem_ok ? entry_q[rd_idx] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    removed_r <= removed_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = removed_r;
  assign out_status        = status;
  assign out_entry_count   = 5'(count);

endmodule

// File: src/pil_cell.sv
// one list cell: holds a single entry and trades it with its neighbors
// depends on pil_pkg
module pil_cell
  import pil_pkg::*;
(
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic signed [VAL_W-1:0] ins_value,
  input  logic signed [VAL_W-1:0] left_value,
  input  logic signed [VAL_W-1:0] right_value,
  output logic signed [VAL_W-1:0] entry
);

  logic signed [VAL_W-1:0] entry_r;
  logic signed [VAL_W-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load) begin
      entry_nxt = ins_value;
    end else if (ctl.shift_up) begin
      entry_nxt = left_value;
    end else if (ctl.shift_dn) begin
      entry_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// File: src/pil_ctrl.sv
// list control: entry count, request checks and status register
// depends on pil_pkg and assert_macros.svh
`include "assert_macros.svh"
module pil_ctrl
  import pil_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             kind,
  input  logic [POS_W-1:0] position,
  output op_t              op,
  output status_t          status,
  output logic [CNT_W-1:0] count
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  status_t          status_r;
  status_t          status_nxt;
  logic             full;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] cnt_c;

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign pos_c = CMP_W'(position);
  assign cnt_c = CMP_W'(count_r);

  // remove needs pos below count, which also rules out the empty list
  assign op.ins_ok = (kind == KIND_INSERT) && !full && (pos_c <= cnt_c);
  assign op.rem_ok = (kind == KIND_REMOVE) && (pos_c < cnt_c);

  always_comb begin
    count_nxt  = count_r;
    status_nxt = status_r;
    if (accept) begin
      if (op.ins_ok) begin
        count_nxt  = count_r + 1'b1;
        status_nxt = ST_OK;
      end else if (op.rem_ok) begin
        count_nxt  = count_r - 1'b1;
        status_nxt = ST_OK;
      end else if (kind == KIND_INSERT) begin
        status_nxt = ST_INS_REFUSED;
      end else begin
        status_nxt = ST_REM_REFUSED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      status_r <= ST_OK;
    end else begin
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
  end

  assign status = status_r;
  assign count  = count_r;

  `PIL_ASSERT(a_count_max, count_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `PIL_ASSERT_IMPL(a_ins_inc, rst_n && accept && op.ins_ok, count_r == CNT_W'($past(count_r) + 1'b1), "insert did not grow count")
  `PIL_ASSERT_IMPL(a_refuse_hold, rst_n && accept && !op.ins_ok && !op.rem_ok, $stable(count_r) && (status_r != ST_OK), "refused item changed count")

endmodule

// File: verif/positional_insert_remove_list_tb.sv
// self-checking testbench of the positional insert/remove list
// holds its own shadow of the list and compares every result field
// depends on pil_pkg and positional_insert_remove_list
module positional_insert_remove_list_tb
  import pil_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_DIRECTED = 25;
  localparam int NUM_RANDOM   = 1750;
  localparam int CYCLE_LIMIT  = 400000;

  // one result as the block should report it
  typedef struct packed {
    logic signed [VAL_W-1:0] removed_value;
    status_t                 status;
    logic [4:0]              entry_count;
  } list_result_t;

  // directed row: the item, plus a typed-in answer where it is obvious
  typedef struct packed {
    logic                    kind;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    logic                    typed;
    list_result_t            answer;
  } list_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic                    in_kind;
  logic [POS_W-1:0]        in_position;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_removed_value;
  logic [1:0]              out_status;
  logic [4:0]              out_entry_count;

  // shadow copy of the list, updated as each item is accepted
  logic signed [VAL_W-1:0] shadow_entries [CAPACITY];
  int                      shadow_count;

  // results still owed by the block, oldest first
  list_result_t            owed_results [$];
  int                      mismatches;
  int                      cycle_count;

  // directed rows: empty list, bad positions, value extremes, head/tail forms,
  // then fill to capacity and poke at the full list
  list_row_t directed_rows [NUM_DIRECTED] = '{
    // remove from an empty list
    '{KIND_REMOVE, 5'd0,  32'sh0000_0000, 1'b1, '{32'sh0, ST_REM_REFUSED, 5'd0}},
    // insert far past the end of an empty list
    '{KIND_INSERT, 5'd31, 32'sh1234_5678, 1'b1, '{32'sh0, ST_INS_REFUSED, 5'd0}},
    '{KIND_INSERT, 5'd0,  32'sh7FFF_FFFF, 1'b1, '{32'sh0, ST_OK, 5'd1}},
    // tail insert with the most negative value
    '{KIND_INSERT, 5'd1,  32'sh8000_0000, 1'b1, '{32'sh0, ST_OK, 5'd2}},
    // head insert
    '{KIND_INSERT, 5'd0,  32'shFFFF_FFFF, 1'b1, '{32'sh0, ST_OK, 5'd3}},
    '{KIND_INSERT, 5'd1,  32'sh0000_0000, 1'b1, '{32'sh0, ST_OK, 5'd4}},
    // remove exactly at count, then at the top of the position field
    '{KIND_REMOVE, 5'd4,  32'sh0000_0000, 1'b1, '{32'sh0, ST_REM_REFUSED, 5'd4}},
    '{KIND_REMOVE, 5'd31, 32'shFFFF_FFFF, 1'b1, '{32'sh0, ST_REM_REFUSED, 5'd4}},
    // tail remove must return the last entry
    '{KIND_REMOVE, 5'd3,  32'sh0000_0000, 1'b1, '{32'sh8000_0000, ST_OK, 5'd3}},
    // fill up to capacity, shifts checked by the shadow list
    '{KIND_INSERT, 5'd3,  32'shA5A5_A5A5, 1'b0, '0},
    '{KIND_INSERT, 5'd0,  32'sh5A5A_5A5A, 1'b0, '0},
    '{KIND_INSERT, 5'd2,  32'sh0000_0001, 1'b0, '0},
    '{KIND_INSERT, 5'd5,  32'sh8000_0001, 1'b0, '0},
    '{KIND_INSERT, 5'd1,  32'sh7FFF_FFFE, 1'b0, '0},
    '{KIND_INSERT, 5'd8,  32'sh0F0F_0F0F, 1'b0, '0},
    '{KIND_INSERT, 5'd4,  32'shF0F0_F0F0, 1'b0, '0},
    '{KIND_INSERT, 5'd10, 32'sh3333_3333, 1'b0, '0},
    '{KIND_INSERT, 5'd7,  32'shCCCC_CCCC, 1'b0, '0},
    '{KIND_INSERT, 5'd12, 32'sh0101_0101, 1'b0, '0},
    '{KIND_INSERT, 5'd6,  32'shFEFE_FEFE, 1'b0, '0},
    '{KIND_INSERT, 5'd14, 32'sh1111_1111, 1'b0, '0},
    '{KIND_INSERT, 5'd15, 32'shEEEE_EEEE, 1'b0, '0},
    // list is full now: any insert is refused
    '{KIND_INSERT, 5'd16, 32'sh5555_5555, 1'b1, '{32'sh0, ST_INS_REFUSED, 5'd16}},
    // head remove from the full list
    '{KIND_REMOVE, 5'd0,  32'sh0000_0000, 1'b0, '0},
    // remove at count after the list shrank back to 15
    '{KIND_REMOVE, 5'd15, 32'sh0000_0000, 1'b1, '{32'sh0, ST_REM_REFUSED, 5'd15}}
  };

  positional_insert_remove_list DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_removed_value (out_removed_value),
    .out_status        (out_status),
    .out_entry_count   (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // apply one item to the shadow list and return what the block must report
  function automatic list_result_t list_apply(logic kind, logic [POS_W-1:0] position,
                                              logic signed [VAL_W-1:0] value);
    list_result_t res;
    int           i;
    res.removed_value = '0;
    res.status        = ST_OK;
    if (kind == KIND_INSERT) begin
      if (shadow_count >= CAPACITY || int'(position) > shadow_count) begin
        res.status = ST_INS_REFUSED;
      end else begin
        // open a hole at position, everything above moves up
        for (i = shadow_count; i > int'(position); i--) begin
          shadow_entries[i] = shadow_entries[i-1];
        end
        shadow_entries[position] = value;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0 || int'(position) >= shadow_count) begin
        res.status = ST_REM_REFUSED;
      end else begin
        // take the entry out and close the gap
        res.removed_value = shadow_entries[position];
        for (i = int'(position); i + 1 < shadow_count; i++) begin
          shadow_entries[i] = shadow_entries[i+1];
        end
        shadow_count--;
      end
    end
    res.entry_count = 5'(shadow_count);
    return res;
  endfunction

  // present one item, hold it until taken, then optionally go idle
  task automatic send_item(input logic kind, input logic [POS_W-1:0] position,
                           input logic signed [VAL_W-1:0] value, input logic typed,
                           input list_result_t answer, input int gap);
    list_result_t res;
    start       <= 1'b1;
    in_kind     <= kind;
    in_position <= position;
    in_value    <= value;
    // busy is sampled as it stood during the cycle that just ended
    do @(posedge clk); while (busy);
    res = list_apply(kind, position, value);
    owed_results.push_back(typed ? answer : res);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // mostly back to back, sometimes a short pause, rarely a long one
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // stimulus
  initial begin
    int               n;
    int               insert_pct;
    bit               quiet;
    logic             kind;
    logic [POS_W-1:0] position;
    logic signed [VAL_W-1:0] value;
    list_result_t     no_answer;

    no_answer   = '0;
    start       = 1'b0;
    in_kind     = KIND_INSERT;
    in_position = '0;
    in_value    = '0;
    rst_n       = 1'b0;
    shadow_count = 0;
    for (n = 0; n < CAPACITY; n++) shadow_entries[n] = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows, gaps kept random so they land between shifts too
    for (n = 0; n < NUM_DIRECTED; n++) begin
      send_item(directed_rows[n].kind, directed_rows[n].position, directed_rows[n].value,
                directed_rows[n].typed, directed_rows[n].answer, pick_gap(1'b0));
    end

    insert_pct = 50;
    quiet      = 1'b0;
    for (n = 0; n < NUM_RANDOM; n++) begin
      // new phase every 64 items: drift toward full, toward empty, or hover
      if (n % 64 == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 80;
          1: insert_pct = 20;
          default: insert_pct = 50;
        endcase
        quiet = ($urandom_range(3) == 0);
      end

      // hold off until the block has answered everything so far
      if (n == NUM_RANDOM / 2) begin
        start <= 1'b0;
        do @(posedge clk); while (owed_results.size() != 0);
      end

      kind = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;

      // mostly legal positions, with the ends favored; some anywhere in the field
      case ($urandom_range(9))
        0, 1: position = 5'($urandom_range(31));
        2: position = (kind == KIND_INSERT) ? 5'(shadow_count)
                                            : 5'((shadow_count > 0) ? shadow_count - 1 : 0);
        3: position = '0;
        default: begin
          if (kind == KIND_INSERT) position = 5'($urandom_range(shadow_count, 0));
          else if (shadow_count > 0) position = 5'($urandom_range(shadow_count - 1, 0));
          else position = 5'($urandom_range(31));
        end
      endcase

      case ($urandom_range(19))
        0: value = 32'sh7FFF_FFFF;
        1: value = 32'sh8000_0000;
        2: value = 32'shFFFF_FFFF;
        3: value = '0;
        default: value = $urandom;
      endcase

      send_item(kind, position, value, 1'b0, no_answer, pick_gap(quiet));
    end
    start <= 1'b0;

    // drain: the block answers in the cycle after each item; allow a few more
    while (owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // result checker: every strobe must match the oldest owed result
  always @(posedge clk) begin
    list_result_t exp_res;
    if (rst_n && out_valid) begin
      if (owed_results.size() == 0) begin
        $error("result with nothing owed: removed_value %0d status %0d entry_count %0d",
               out_removed_value, out_status, out_entry_count);
        mismatches++;
      end else begin
        exp_res = owed_results.pop_front();
        if (out_removed_value !== exp_res.removed_value) begin
          $error("removed_value: expected %0d, got %0d", exp_res.removed_value,
                 out_removed_value);
          mismatches++;
        end
        if (out_status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_status);
          mismatches++;
        end
        if (out_entry_count !== exp_res.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_res.entry_count,
                 out_entry_count);
          mismatches++;
        end
      end
    end
  end

  // watchdog against a hung handshake
  initial mismatches = 0;
  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
